[rtl/mmd_pkg.sv]
package mmd_pkg;

  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_SIZE_LOG2 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_SIZE_LOG2  = 2'd1;

  localparam logic [CFG_W-1:0] IMAGE_LOG2_RST = 4'd8;
  localparam logic [CFG_W-1:0] TILE_LOG2_RST  = 4'd4;

  localparam int CH_W    = 8;
  localparam int LANES   = 4;
  localparam int PIX_W   = CH_W * LANES;
  localparam int PSUM_W  = CH_W + 1;
  localparam int LINE_W  = PSUM_W * LANES;
  localparam int SUM_W   = PSUM_W + 1;
  localparam int LVL_W   = 4;
  localparam int COORD_W = 7;
  localparam int OUT_DATA_W = 56;

  typedef logic [LINE_W-1:0]        line_word_t;
  typedef logic [SUM_W*LANES-1:0]   lane_sum_t;
  typedef logic [PIX_W-1:0]         pixel_t;

endpackage

[rtl/mmd_add4.sv]
module mmd_add4
  import mmd_pkg::*;
(
  input  line_word_t op_a,
  input  line_word_t op_b,
  output lane_sum_t  sum
);

  // four independent per-channel adders, shared by pair and quad sums
  for (genvar c = 0; c < LANES; c++) begin : g_lane
    assign sum[c*SUM_W +: SUM_W] = SUM_W'(op_a[c*PSUM_W +: PSUM_W])
                                 + SUM_W'(op_b[c*PSUM_W +: PSUM_W]);
  end

endmodule

[rtl/atlas_mipmap_box_downsampler_top.sv]
// channel | dir | handshake          | payload
// cfg     | in  | cfg_wr_en          | cfg_wr_idx, cfg_wr_data
// in      | in  | in_tvalid/tready   | in_tdata: red, green, blue, alpha
// out     | out | out_tvalid/tready  | out_tdata, out_tlast, out_tuser
//
// a pixel is worked through one mip level at a time and yields no result when
// tile_size_log2 is 0; the levels share the one four-lane adder, and a level
// that yields a result makes one registered read of the line memory.
// in_tready is high only while the sequencer is idle; a result sits in the
// output register and stalls the sequencer only when the next one is ready.
// rst_n is synchronous; the line memory and left pixels need no clearing.
module atlas_mipmap_box_downsampler_top
  import mmd_pkg::*;
#(
  parameter int MAX_SIZE_LOG2 = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_wr_idx,
  input  logic [CFG_W-1:0]      cfg_wr_data,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [PIX_W-1:0]      in_tdata,   // red, green, blue, alpha
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // level[3:0], out_x, out_y, out_red, out_green, out_blue, out_alpha, zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast,  // last_of_run
  output logic                  out_tuser   // image_done
);

  localparam int POS_W  = MAX_SIZE_LOG2;
  localparam int DEPTH  = 1 << MAX_SIZE_LOG2;
  localparam int LIDX_W = (MAX_SIZE_LOG2 > 1) ? $clog2(MAX_SIZE_LOG2) : 1;
  localparam logic [CFG_W-1:0] MAX_LOG2_C = CFG_W'(MAX_SIZE_LOG2);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_LEVEL = 2'd1;
  localparam logic [1:0] ST_AVG   = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CFG_W-1:0] img_r, tile_r;
  logic [POS_W-1:0] col_r, row_r;
  logic [POS_W-1:0] x_r, y_r;
  logic [LVL_W-1:0] lvl_r, lvl_nxt;
  pixel_t           cur_r;
  line_word_t       pair_r, mem_q_r;
  logic             out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic             out_last_r, out_done_r;

  pixel_t     left_r [MAX_SIZE_LOG2];
  line_word_t line_mem [DEPTH];

  logic [CFG_W-1:0] s_eff, t_eff;
  logic [POS_W:0]   size_w;
  logic [POS_W-1:0] size_m1;
  logic [LVL_W-1:0] lvl_m1;
  logic [POS_W-1:0] lx, ly, half_x, half_y;
  logic [POS_W-1:0] line_idx;
  logic [COORD_W+POS_W-1:0] ext_x, ext_y;
  pixel_t     left_pix, avg_pix;
  line_word_t op_a, op_b, pix_a, pix_b, pair_w;
  lane_sum_t  sum;
  logic       in_xfer, out_xfer, can_load, last_w, done_w;
  logic       mem_we, mem_re, left_we;

  // effective sizes after saturation
  always_comb begin
    s_eff = img_r;
    if (img_r == '0) begin
      s_eff = CFG_W'(1);
    end else if (img_r > MAX_LOG2_C) begin
      s_eff = MAX_LOG2_C;
    end
    t_eff = (tile_r > s_eff) ? s_eff : tile_r;
  end

  assign size_w  = (POS_W+1)'(1) << s_eff;
  assign size_m1 = POS_W'(size_w - (POS_W+1)'(1));

  assign lvl_m1   = lvl_r - LVL_W'(1);
  assign lx       = x_r >> lvl_m1;
  assign ly       = y_r >> lvl_m1;
  assign half_x   = lx >> 1;
  assign half_y   = ly >> 1;
  assign line_idx = POS_W'(size_w - (size_w >> lvl_m1) + (POS_W+1)'(half_x));
  assign left_pix = left_r[lvl_m1[LIDX_W-1:0]];

  for (genvar c = 0; c < LANES; c++) begin : g_lane
    assign pix_a[c*PSUM_W +: PSUM_W]  = PSUM_W'(left_pix[c*CH_W +: CH_W]);
    assign pix_b[c*PSUM_W +: PSUM_W]  = PSUM_W'(cur_r[c*CH_W +: CH_W]);
    assign pair_w[c*PSUM_W +: PSUM_W] = sum[c*SUM_W +: PSUM_W];
    // divide by 4 of the quad sum
    assign avg_pix[c*CH_W +: CH_W]    = sum[c*SUM_W+2 +: CH_W];
  end

  assign op_a = (state_r == ST_AVG) ? mem_q_r : pix_a;
  assign op_b = (state_r == ST_AVG) ? pair_r  : pix_b;

  mmd_add4 u_add4 (
    .op_a (op_a),
    .op_b (op_b),
    .sum  (sum)
  );

  assign ext_x = {{COORD_W{1'b0}}, half_x};
  assign ext_y = {{COORD_W{1'b0}}, half_y};

  // next level yields a result only if both its position bits are odd
  assign last_w = !((lvl_r < t_eff) && half_x[0] && half_y[0]);
  assign done_w = last_w && (x_r == size_m1) && (y_r == size_m1);

  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_xfer  = out_valid_r && out_tready;
  assign can_load  = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    lvl_nxt   = lvl_r;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    left_we   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer && (t_eff != '0)) begin
          state_nxt = ST_LEVEL;
          lvl_nxt   = LVL_W'(1);
        end
      end
      ST_LEVEL: begin
        if (!lx[0]) begin
          left_we   = 1'b1;
          state_nxt = ST_IDLE;
        end else if (!ly[0]) begin
          mem_we    = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          mem_re    = 1'b1;
          state_nxt = ST_AVG;
        end
      end
      ST_AVG: begin
        if (can_load) begin
          // the next level still has to keep its left pixel or pair sum
          if (lvl_r < t_eff) begin
            state_nxt = ST_LEVEL;
            lvl_nxt   = lvl_r + LVL_W'(1);
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lvl_r       <= '0;
      img_r       <= IMAGE_LOG2_RST;
      tile_r      <= TILE_LOG2_RST;
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      lvl_r   <= lvl_nxt;
      if (state_r == ST_AVG && can_load) begin
        out_valid_r <= 1'b1;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
      if (in_xfer) begin
        if ((col_r & size_m1) == size_m1) begin
          col_r <= '0;
          row_r <= ((row_r & size_m1) == size_m1) ? '0 : (row_r & size_m1) + POS_W'(1);
        end else begin
          col_r <= (col_r & size_m1) + POS_W'(1);
          row_r <= row_r & size_m1;
        end
      end
      // a write to either size register restarts the image
      if (cfg_wr_en && (cfg_wr_idx == REG_IMAGE_SIZE_LOG2 ||
                        cfg_wr_idx == REG_TILE_SIZE_LOG2)) begin
        if (cfg_wr_idx == REG_IMAGE_SIZE_LOG2) begin
          img_r <= cfg_wr_data;
        end else begin
          tile_r <= cfg_wr_data;
        end
        col_r <= '0;
        row_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cur_r <= in_tdata;
      x_r   <= col_r & size_m1;
      y_r   <= row_r & size_m1;
    end
    if (mem_re) begin
      pair_r <= pair_w;
    end
    if (left_we) begin
      left_r[lvl_m1[LIDX_W-1:0]] <= cur_r;
    end
    if (state_r == ST_AVG && can_load) begin
      cur_r      <= avg_pix;
      out_data_r <= {{(OUT_DATA_W-LVL_W-2*COORD_W-PIX_W){1'b0}}, avg_pix,
                     ext_y[COORD_W-1:0], ext_x[COORD_W-1:0], lvl_r};
      out_last_r <= last_w;
      out_done_r <= done_w;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[line_idx] <= pair_w;
    end
    if (mem_re) begin
      mem_q_r <= line_mem[line_idx];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_done_r;

  a_level_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[LVL_W-1:0] != '0)
    else $error("result with level zero");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> out_tlast)
    else $error("image end flagged on a result that is not last of its run");

  a_avg_after_level: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_AVG) |-> ($past(state_r) == ST_LEVEL || $past(state_r) == ST_AVG))
    else $error("average step entered without a level step");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && t_eff != '0) |=> !in_tready)
    else $error("ready again right after a pixel transfer");

endmodule
